### sv/stream_timestamp_health_monitor_assert.svh
// Assertion macros for the stream timestamp health monitor.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef STREAM_TIMESTAMP_HEALTH_MONITOR_ASSERT_SVH
`define STREAM_TIMESTAMP_HEALTH_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shm: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SHM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shm: assertion failed");

`endif

### sv/shm_pkg.sv
package shm_pkg;

    localparam int FUNC_BITS     = 2;
    localparam int STAMP_BITS    = 63;
    localparam int CFG_BITS      = 40;
    localparam int CFG_ADDR_BITS = 2;
    localparam int SUM_BITS      = 64;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS + 1);
    localparam int REASON_BITS   = 3;
    localparam int OUT_CNT_BITS  = 32;
    localparam int OUT_S_BITS    = 48;
    localparam int OUT_U_BITS    = 47;

    // Queue between the front and the back; the depth must be a power of two.
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    localparam logic [CFG_BITS-1:0] GAP_MIN_NS         = 40'd1000000;
    localparam logic [CFG_BITS-1:0] GAP_RESET_NS       = 40'd100000000;
    localparam logic [CFG_BITS-1:0] JITTER_HIGH_RESET  = 40'd10000000;
    localparam logic [CFG_BITS-1:0] JITTER_WARN_RESET  = 40'd2000000;

    localparam logic signed [SUM_BITS-1:0] S48_MAX_W = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_BITS-1:0] S48_MIN_W = 64'shFFFF_8000_0000_0000;
    localparam logic [SUM_BITS-1:0]        S48_MAG_MIN = 64'h0000_8000_0000_0000;
    localparam logic [SUM_BITS-1:0]        U32_MAX_W = 64'h0000_0000_FFFF_FFFF;
    localparam logic [OUT_S_BITS-1:0]      S48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_S_BITS-1:0]      S48_MIN = 48'h8000_0000_0000;
    localparam logic [OUT_U_BITS-1:0]      U47_MAX = 47'h7FFF_FFFF_FFFF;
    localparam logic [OUT_CNT_BITS-1:0]    U32_MAX = 32'hFFFF_FFFF;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_OBSERVE  = 2'd0,
        FUNC_WINDOW   = 2'd1,
        FUNC_LIFETIME = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CLS_FIRST,
        CLS_REORDER,
        CLS_GAP,
        CLS_NORMAL
    } t_class;

    typedef struct packed {
        t_func  func;
        t_class cls;
    } t_ctl;

    typedef enum logic [REASON_BITS-1:0] {
        REASON_OK          = 3'd0,
        REASON_REORDER     = 3'd1,
        REASON_GAP         = 3'd2,
        REASON_JITTER_HIGH = 3'd3,
        REASON_JITTER_WARN = 3'd4
    } t_reason;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_GAP_THRESHOLD = 2'd0,
        CFG_JITTER_HIGH   = 2'd1,
        CFG_JITTER_WARN   = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } t_eng_state;

    function automatic logic [OUT_CNT_BITS-1:0] sat_u32(input logic [SUM_BITS-1:0] v);
        return (v > U32_MAX_W) ? U32_MAX : v[OUT_CNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_S_BITS-1:0] sat_s48(input logic signed [SUM_BITS-1:0] v);
        logic [OUT_S_BITS-1:0] r;
        if (v > S48_MAX_W) begin
            r = S48_MAX;
        end else if (v < S48_MIN_W) begin
            r = S48_MIN;
        end else begin
            r = v[OUT_S_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [OUT_U_BITS-1:0] sat_u47(input logic signed [SUM_BITS-1:0] v);
        logic [OUT_U_BITS-1:0] r;
        if (v[SUM_BITS-1]) begin
            r = '0;
        end else if (v > S48_MAX_W) begin
            r = U47_MAX;
        end else begin
            r = v[OUT_U_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### sv/shm_div.sv
module shm_div #(
    parameter int DEN_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [shm_pkg::SUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]           i_den,
    output logic                          o_done,
    output logic [shm_pkg::SUM_BITS-1:0]  o_quot
);
    import shm_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [SUM_BITS-1:0]     r_num;
    logic [DEN_BITS-1:0]     r_rem;
    logic [DEN_BITS-1:0]     r_den;

    logic [DEN_BITS:0]       w_rem_sh;
    logic [DEN_BITS:0]       w_rem_sub;
    logic                    w_ge;
    logic [DEN_BITS-1:0]     w_rem_next;

    // Restoring division, one quotient bit per cycle; the quotient shifts in
    // from the bottom of the numerator register as the numerator leaves the top.
    always_comb begin
        w_rem_sh   = {r_rem, r_num[SUM_BITS-1]};
        w_ge       = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub  = w_rem_sh - {1'b0, r_den};
        w_rem_next = w_ge ? w_rem_sub[DEN_BITS-1:0] : w_rem_sh[DEN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(SUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_BITS-2:0], w_ge};
            r_rem <= w_rem_next;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

### sv/shm_front.sv
module shm_front #(
    parameter int TIME_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [shm_pkg::FUNC_BITS-1:0]   i_func,
    input  logic [shm_pkg::STAMP_BITS-1:0]  i_header_stamp,
    input  logic [shm_pkg::STAMP_BITS-1:0]  i_receive_time,
    input  logic [shm_pkg::CFG_BITS-1:0]    i_gap_thr,
    output logic                            o_valid,
    input  logic                            i_pop,
    output shm_pkg::t_ctl                   o_ctl,
    output logic signed [TIME_BITS-1:0]     o_delay,
    output logic signed [TIME_BITS-1:0]     o_period
);
    import shm_pkg::*;

    localparam logic [SUM_BITS-1:0] TMAX =
        {{(SUM_BITS + 1 - TIME_BITS){1'b0}}, {(TIME_BITS - 1){1'b1}}};
    localparam logic [SUM_BITS-1:0] TMIN = ~TMAX;

    logic [STAMP_BITS-1:0]       r_prev_stamp;
    logic                        r_prev_valid;
    t_ctl                        r_q_ctl    [QDEPTH];
    logic signed [TIME_BITS-1:0] r_q_delay  [QDEPTH];
    logic signed [TIME_BITS-1:0] r_q_period [QDEPTH];
    logic [QPTR_BITS-1:0]        r_wr_ptr;
    logic [QPTR_BITS-1:0]        r_rd_ptr;
    logic [QCNT_BITS-1:0]        r_count;

    logic                        w_accept;
    logic                        w_enq;
    logic signed [SUM_BITS-1:0]  w_delay_raw;
    logic signed [SUM_BITS-1:0]  w_period_raw;
    logic signed [TIME_BITS-1:0] w_delay;
    logic signed [TIME_BITS-1:0] w_period;
    t_ctl                        w_ctl;

    assign w_accept = i_push && !o_full;

    assign w_delay_raw  = $signed({1'b0, i_receive_time}) - $signed({1'b0, i_header_stamp});
    assign w_period_raw = $signed({1'b0, i_header_stamp}) - $signed({1'b0, r_prev_stamp});

    always_comb begin
        if (w_delay_raw > $signed(TMAX)) begin
            w_delay = TMAX[TIME_BITS-1:0];
        end else if (w_delay_raw < $signed(TMIN)) begin
            w_delay = TMIN[TIME_BITS-1:0];
        end else begin
            w_delay = w_delay_raw[TIME_BITS-1:0];
        end

        // Only used when the period is not negative, so the upper bound is enough.
        if (w_period_raw > $signed(TMAX)) begin
            w_period = TMAX[TIME_BITS-1:0];
        end else begin
            w_period = w_period_raw[TIME_BITS-1:0];
        end

        w_ctl.func = t_func'(i_func);
        if (!r_prev_valid) begin
            w_ctl.cls = CLS_FIRST;
        end else if (w_period_raw[SUM_BITS-1]) begin
            w_ctl.cls = CLS_REORDER;
        end else if (w_period_raw > $signed({{(SUM_BITS - CFG_BITS){1'b0}}, i_gap_thr})) begin
            w_ctl.cls = CLS_GAP;
        end else begin
            w_ctl.cls = CLS_NORMAL;
        end
    end

    // The unused selector is taken from the port and then dropped.
    always_comb begin
        unique case (i_func) inside
            FUNC_OBSERVE, FUNC_WINDOW, FUNC_LIFETIME: w_enq = w_accept;
            default: w_enq = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_BITS'(w_enq) - QCNT_BITS'(i_pop);
            if (w_enq && (w_ctl.func == FUNC_OBSERVE)) begin
                r_prev_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q_ctl[r_wr_ptr]    <= w_ctl;
            r_q_delay[r_wr_ptr]  <= w_delay;
            r_q_period[r_wr_ptr] <= w_period;
        end
        if (w_enq && (w_ctl.func == FUNC_OBSERVE)) begin
            r_prev_stamp <= i_header_stamp;
        end
    end

    assign o_full   = (r_count == QCNT_BITS'(QDEPTH));
    assign o_valid  = (r_count != '0);
    assign o_ctl    = r_q_ctl[r_rd_ptr];
    assign o_delay  = r_q_delay[r_rd_ptr];
    assign o_period = r_q_period[r_rd_ptr];

endmodule

### sv/shm_engine.sv
module shm_engine #(
    parameter int COUNT_BITS = 32,
    parameter int TIME_BITS  = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  shm_pkg::t_ctl                     i_ctl,
    input  logic signed [TIME_BITS-1:0]       i_delay,
    input  logic signed [TIME_BITS-1:0]       i_period,
    output logic                              o_pop,
    input  logic [shm_pkg::CFG_BITS-1:0]      i_jitter_high,
    input  logic [shm_pkg::CFG_BITS-1:0]      i_jitter_warn,
    output logic                              o_empty,
    input  logic                              i_out_pop,
    output logic [shm_pkg::REASON_BITS-1:0]   o_reason_code,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]  o_total_count,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]  o_window_count,
    output logic signed [shm_pkg::OUT_S_BITS-1:0] o_last_delay_ns,
    output logic signed [shm_pkg::OUT_S_BITS-1:0] o_average_delay_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]    o_max_delay_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]    o_last_period_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]    o_last_jitter_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]    o_max_jitter_ns,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]  o_reordered_count,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]  o_gap_count,
    output logic [shm_pkg::OUT_U_BITS-1:0]    o_max_gap_ns
);
    import shm_pkg::*;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;

    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0] a,
        input logic signed [SUM_BITS-1:0] b
    );
        logic signed [SUM_BITS-1:0] s;
        logic                       ovf;
        s   = a + b;
        ovf = (a[SUM_BITS-1] == b[SUM_BITS-1]) && (s[SUM_BITS-1] != a[SUM_BITS-1]);
        if (ovf) begin
            s = a[SUM_BITS-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    t_eng_state r_state;
    t_eng_state n_state;

    logic                        r_prev_period_valid;
    logic signed [TIME_BITS-1:0] r_prev_period;
    logic [COUNT_BITS-1:0]       r_samples_total;
    logic [COUNT_BITS-1:0]       r_samples_window;
    logic signed [SUM_BITS-1:0]  r_sum_total;
    logic signed [SUM_BITS-1:0]  r_sum_window;
    logic signed [TIME_BITS-1:0] r_delay_last;
    logic signed [TIME_BITS-1:0] r_dpeak_total;
    logic signed [TIME_BITS-1:0] r_dpeak_window;
    logic signed [TIME_BITS-1:0] r_period_last;
    logic signed [TIME_BITS-1:0] r_jitter_last;
    logic signed [TIME_BITS-1:0] r_jpeak_total;
    logic signed [TIME_BITS-1:0] r_jpeak_window;
    logic [COUNT_BITS-1:0]       r_reo_total;
    logic [COUNT_BITS-1:0]       r_reo_window;
    logic [COUNT_BITS-1:0]       r_gaps_total;
    logic [COUNT_BITS-1:0]       r_gaps_window;
    logic signed [TIME_BITS-1:0] r_gap_peak;

    logic                        r_out_valid;
    logic                        r_avg_neg;
    logic                        r_avg_zero;
    logic [REASON_BITS-1:0]      r_out_reason;
    logic [OUT_CNT_BITS-1:0]     r_out_total;
    logic [OUT_CNT_BITS-1:0]     r_out_window;
    logic [OUT_S_BITS-1:0]       r_out_last_delay;
    logic [OUT_S_BITS-1:0]       r_out_avg;
    logic [OUT_U_BITS-1:0]       r_out_max_delay;
    logic [OUT_U_BITS-1:0]       r_out_last_period;
    logic [OUT_U_BITS-1:0]       r_out_last_jitter;
    logic [OUT_U_BITS-1:0]       r_out_max_jitter;
    logic [OUT_CNT_BITS-1:0]     r_out_reo;
    logic [OUT_CNT_BITS-1:0]     r_out_gaps;
    logic [OUT_U_BITS-1:0]       r_out_max_gap;

    logic                        w_out_free;
    logic                        w_obs;
    logic                        w_query;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [SUM_BITS-1:0]         w_div_quot;
    logic [SUM_BITS-1:0]         w_quot_neg;
    logic [OUT_S_BITS-1:0]       w_avg;
    logic                        w_win;
    logic signed [SUM_BITS-1:0]  w_delay_ext;
    logic signed [TIME_BITS-1:0] w_jdiff;
    logic signed [TIME_BITS-1:0] w_jitter;
    logic [COUNT_BITS-1:0]       w_sel_cnt;
    logic signed [SUM_BITS-1:0]  w_sel_sum;
    logic signed [TIME_BITS-1:0] w_sel_dpeak;
    logic signed [TIME_BITS-1:0] w_sel_jpeak;
    logic [COUNT_BITS-1:0]       w_sel_reo;
    logic [COUNT_BITS-1:0]       w_sel_gaps;
    logic [SUM_BITS-1:0]         w_sum_mag;
    logic [SUM_BITS-1:0]         w_jpeak_u;
    t_reason                     w_reason;

    assign w_out_free = !r_out_valid || i_out_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Observes retire straight away; a query holds the back until its average is done.
    always_comb begin
        n_state     = r_state;
        w_obs       = 1'b0;
        w_query     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (i_valid) begin
                    if (i_ctl.func == FUNC_OBSERVE) begin
                        w_obs = 1'b1;
                    end else if (w_out_free) begin
                        w_query     = 1'b1;
                        w_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
        o_pop = w_obs || w_query;
    end

    always_comb begin
        w_delay_ext = SUM_BITS'(i_delay);
        w_jdiff     = i_period - r_prev_period;
        w_jitter    = w_jdiff[TIME_BITS-1] ? (r_prev_period - i_period) : w_jdiff;

        w_win       = (i_ctl.func == FUNC_WINDOW);
        w_sel_cnt   = w_win ? r_samples_window : r_samples_total;
        w_sel_sum   = w_win ? r_sum_window     : r_sum_total;
        w_sel_dpeak = w_win ? r_dpeak_window   : r_dpeak_total;
        w_sel_jpeak = w_win ? r_jpeak_window   : r_jpeak_total;
        w_sel_reo   = w_win ? r_reo_window     : r_reo_total;
        w_sel_gaps  = w_win ? r_gaps_window    : r_gaps_total;
        w_sum_mag   = w_sel_sum[SUM_BITS-1] ? (~w_sel_sum + 1'b1) : w_sel_sum;

        // Peak jitter never goes negative, so a zero extension compares correctly.
        w_jpeak_u = SUM_BITS'($unsigned(w_sel_jpeak));
        if (|w_sel_reo) begin
            w_reason = REASON_REORDER;
        end else if (|w_sel_gaps) begin
            w_reason = REASON_GAP;
        end else if (w_jpeak_u > SUM_BITS'(i_jitter_high)) begin
            w_reason = REASON_JITTER_HIGH;
        end else if (w_jpeak_u > SUM_BITS'(i_jitter_warn)) begin
            w_reason = REASON_JITTER_WARN;
        end else begin
            w_reason = REASON_OK;
        end

        w_quot_neg = ~w_div_quot + 1'b1;
        if (r_avg_zero) begin
            w_avg = '0;
        end else if (r_avg_neg) begin
            w_avg = (w_div_quot > S48_MAG_MIN) ? S48_MIN : w_quot_neg[OUT_S_BITS-1:0];
        end else begin
            w_avg = (w_div_quot > $unsigned(S48_MAX_W)) ? S48_MAX : w_div_quot[OUT_S_BITS-1:0];
        end
    end

    shm_div #(
        .DEN_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_sum_mag),
        .i_den   (w_sel_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_period_valid <= 1'b0;
            r_prev_period       <= '0;
            r_samples_total     <= '0;
            r_samples_window    <= '0;
            r_sum_total         <= '0;
            r_sum_window        <= '0;
            r_delay_last        <= '0;
            r_dpeak_total       <= '0;
            r_dpeak_window      <= '0;
            r_period_last       <= '0;
            r_jitter_last       <= '0;
            r_jpeak_total       <= '0;
            r_jpeak_window      <= '0;
            r_reo_total         <= '0;
            r_reo_window        <= '0;
            r_gaps_total        <= '0;
            r_gaps_window       <= '0;
            r_gap_peak          <= '0;
        end else if (w_obs) begin
            r_delay_last     <= i_delay;
            r_sum_total      <= sat_add(r_sum_total, w_delay_ext);
            r_sum_window     <= sat_add(r_sum_window, w_delay_ext);
            r_samples_total  <= cnt_inc(r_samples_total);
            r_samples_window <= cnt_inc(r_samples_window);
            if (i_delay > r_dpeak_total) begin
                r_dpeak_total <= i_delay;
            end
            if (i_delay > r_dpeak_window) begin
                r_dpeak_window <= i_delay;
            end
            unique case (i_ctl.cls)
                CLS_FIRST: begin
                end
                CLS_REORDER: begin
                    r_reo_total  <= cnt_inc(r_reo_total);
                    r_reo_window <= cnt_inc(r_reo_window);
                end
                CLS_GAP: begin
                    r_gaps_total        <= cnt_inc(r_gaps_total);
                    r_gaps_window       <= cnt_inc(r_gaps_window);
                    r_period_last       <= i_period;
                    r_prev_period_valid <= 1'b0;
                    if (i_period > r_gap_peak) begin
                        r_gap_peak <= i_period;
                    end
                end
                CLS_NORMAL: begin
                    r_period_last       <= i_period;
                    r_prev_period       <= i_period;
                    r_prev_period_valid <= 1'b1;
                    if (r_prev_period_valid) begin
                        r_jitter_last <= w_jitter;
                        if (w_jitter > r_jpeak_total) begin
                            r_jpeak_total <= w_jitter;
                        end
                        if (w_jitter > r_jpeak_window) begin
                            r_jpeak_window <= w_jitter;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (w_query && w_win) begin
            r_samples_window <= '0;
            r_sum_window     <= '0;
            r_dpeak_window   <= '0;
            r_jpeak_window   <= '0;
            r_reo_window     <= '0;
            r_gaps_window    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_div_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result registers are loaded only while the output is empty or being popped,
    // so a user never sees a partly built result.
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_avg_neg         <= w_sel_sum[SUM_BITS-1];
            r_avg_zero        <= (w_sel_cnt == '0);
            r_out_reason      <= w_reason;
            r_out_total       <= sat_u32(SUM_BITS'(r_samples_total));
            r_out_window      <= sat_u32(SUM_BITS'(w_sel_cnt));
            r_out_last_delay  <= sat_s48(SUM_BITS'(r_delay_last));
            r_out_max_delay   <= sat_u47(SUM_BITS'(w_sel_dpeak));
            r_out_last_period <= sat_u47(SUM_BITS'(r_period_last));
            r_out_last_jitter <= sat_u47(SUM_BITS'(r_jitter_last));
            r_out_max_jitter  <= sat_u47(SUM_BITS'(w_sel_jpeak));
            r_out_reo         <= sat_u32(SUM_BITS'(w_sel_reo));
            r_out_gaps        <= sat_u32(SUM_BITS'(w_sel_gaps));
            r_out_max_gap     <= sat_u47(SUM_BITS'(r_gap_peak));
        end
        if (w_div_done) begin
            r_out_avg <= w_avg;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_reason_code      = r_out_reason;
    assign o_total_count      = r_out_total;
    assign o_window_count     = r_out_window;
    assign o_last_delay_ns    = r_out_last_delay;
    assign o_average_delay_ns = r_out_avg;
    assign o_max_delay_ns     = r_out_max_delay;
    assign o_last_period_ns   = r_out_last_period;
    assign o_last_jitter_ns   = r_out_last_jitter;
    assign o_max_jitter_ns    = r_out_max_jitter;
    assign o_reordered_count  = r_out_reo;
    assign o_gap_count        = r_out_gaps;
    assign o_max_gap_ns       = r_out_max_gap;

endmodule

### sv/stream_timestamp_health_monitor.sv
// Stream timestamp health monitor. Push a transaction to observe a message (func 0) or
// to ask for the window summary (func 1, which then clears the window) or the lifetime
// summary (func 2); func 3 is taken and dropped. The front computes delay, period and
// its class as the transaction is taken and parks it in a four-entry queue, so the
// input keeps flowing while the back is busy or a result waits to be popped. In the
// back an observe retires once it reaches the head, one observe per cycle sustained
// while no query holds the back. A query's result appears once the bit-serial
// divider has formed the average delay (64 steps); a query also waits at the head
// until the previous result has been popped. Results come out in order through a
// single result register. The user must write configuration only while the block is
// idle; the block itself does not enforce this. There is no clearing pass after reset.
`include "stream_timestamp_health_monitor_assert.svh"

module stream_timestamp_health_monitor #(
    parameter int COUNT_BITS = 32,
    parameter int TIME_BITS  = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [shm_pkg::FUNC_BITS-1:0]         i_func,
    input  logic [shm_pkg::STAMP_BITS-1:0]        i_header_stamp,
    input  logic [shm_pkg::STAMP_BITS-1:0]        i_receive_time,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [shm_pkg::REASON_BITS-1:0]       o_reason_code,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]      o_total_count,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]      o_window_count,
    output logic signed [shm_pkg::OUT_S_BITS-1:0] o_last_delay_ns,
    output logic signed [shm_pkg::OUT_S_BITS-1:0] o_average_delay_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]        o_max_delay_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]        o_last_period_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]        o_last_jitter_ns,
    output logic [shm_pkg::OUT_U_BITS-1:0]        o_max_jitter_ns,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]      o_reordered_count,
    output logic [shm_pkg::OUT_CNT_BITS-1:0]      o_gap_count,
    output logic [shm_pkg::OUT_U_BITS-1:0]        o_max_gap_ns,
    input  logic                                  i_cfg_we,
    input  logic [shm_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [shm_pkg::CFG_BITS-1:0]          i_cfg_data
);
    import shm_pkg::*;

    logic [CFG_BITS-1:0]         r_gap_thr;
    logic [CFG_BITS-1:0]         r_jitter_high;
    logic [CFG_BITS-1:0]         r_jitter_warn;
    logic [CFG_BITS-1:0]         n_gap_thr;
    logic [CFG_BITS-1:0]         n_jitter_high;
    logic [CFG_BITS-1:0]         n_jitter_warn;

    logic                        w_q_valid;
    logic                        w_q_pop;
    t_ctl                        w_q_ctl;
    logic signed [TIME_BITS-1:0] w_q_delay;
    logic signed [TIME_BITS-1:0] w_q_period;

    always_comb begin
        n_gap_thr     = r_gap_thr;
        n_jitter_high = r_jitter_high;
        n_jitter_warn = r_jitter_warn;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GAP_THRESHOLD: begin
                    n_gap_thr = (i_cfg_data < GAP_MIN_NS) ? GAP_MIN_NS : i_cfg_data;
                end
                CFG_JITTER_HIGH: n_jitter_high = i_cfg_data;
                CFG_JITTER_WARN: n_jitter_warn = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_thr     <= GAP_RESET_NS;
            r_jitter_high <= JITTER_HIGH_RESET;
            r_jitter_warn <= JITTER_WARN_RESET;
        end else begin
            r_gap_thr     <= n_gap_thr;
            r_jitter_high <= n_jitter_high;
            r_jitter_warn <= n_jitter_warn;
        end
    end

    shm_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_func         (i_func),
        .i_header_stamp (i_header_stamp),
        .i_receive_time (i_receive_time),
        .i_gap_thr      (r_gap_thr),
        .o_valid        (w_q_valid),
        .i_pop          (w_q_pop),
        .o_ctl          (w_q_ctl),
        .o_delay        (w_q_delay),
        .o_period       (w_q_period)
    );

    shm_engine #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_q_valid),
        .i_ctl              (w_q_ctl),
        .i_delay            (w_q_delay),
        .i_period           (w_q_period),
        .o_pop              (w_q_pop),
        .i_jitter_high      (r_jitter_high),
        .i_jitter_warn      (r_jitter_warn),
        .o_empty            (empty),
        .i_out_pop          (pop),
        .o_reason_code      (o_reason_code),
        .o_total_count      (o_total_count),
        .o_window_count     (o_window_count),
        .o_last_delay_ns    (o_last_delay_ns),
        .o_average_delay_ns (o_average_delay_ns),
        .o_max_delay_ns     (o_max_delay_ns),
        .o_last_period_ns   (o_last_period_ns),
        .o_last_jitter_ns   (o_last_jitter_ns),
        .o_max_jitter_ns    (o_max_jitter_ns),
        .o_reordered_count  (o_reordered_count),
        .o_gap_count        (o_gap_count),
        .o_max_gap_ns       (o_max_gap_ns)
    );

    // A small gap threshold is raised to the floor rather than stored.
    `SHM_ASSERT_NEXT(a_gap_floor, i_cfg_we && (i_cfg_addr == CFG_GAP_THRESHOLD) && (i_cfg_data < GAP_MIN_NS), r_gap_thr == GAP_MIN_NS)
    // The back never takes from an empty queue.
    `SHM_ASSERT_IMPL(a_pop_needs_entry, w_q_pop, w_q_valid)
    // A query taken by the back leaves the result side empty while the average is formed.
    `SHM_ASSERT_NEXT(a_query_hides_result, w_q_pop && (w_q_ctl.func != FUNC_OBSERVE), empty)
    // A transaction that is queued is visible to the back in the next cycle.
    `SHM_ASSERT_NEXT(a_enqueue_seen, push && !full && (i_func == FUNC_OBSERVE || i_func == FUNC_WINDOW || i_func == FUNC_LIFETIME), w_q_valid)

endmodule

### tb/sv/stream_timestamp_health_monitor_test.sv
module stream_timestamp_health_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import shm_pkg::*;

    // Codes that the package leaves unnamed: the unused selector and the unused register.
    localparam logic [FUNC_BITS-1:0]     FUNC_IGNORED = 2'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_NONE     = 2'd3;

    localparam logic [STAMP_BITS-1:0] STAMP_TOP   = '1;
    localparam longint                TIME_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint                TIME_BOTTOM = -TIME_TOP - 1;
    localparam longint                SUM_TOP     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint                SUM_BOTTOM  = -SUM_TOP - 1;
    localparam int                    STALL_LIMIT  = 5000;
    localparam int                    DRAIN_CYCLES = 200;
    localparam int                    PHASE_ITEMS  = 150;

    typedef struct {
        t_reason                         reason;
        logic [OUT_CNT_BITS-1:0]         total_count;
        logic [OUT_CNT_BITS-1:0]         window_count;
        logic signed [OUT_S_BITS-1:0]    last_delay;
        logic signed [OUT_S_BITS-1:0]    average_delay;
        logic [OUT_U_BITS-1:0]           max_delay;
        logic [OUT_U_BITS-1:0]           last_period;
        logic [OUT_U_BITS-1:0]           last_jitter;
        logic [OUT_U_BITS-1:0]           max_jitter;
        logic [OUT_CNT_BITS-1:0]         reordered;
        logic [OUT_CNT_BITS-1:0]         gaps;
        logic [OUT_U_BITS-1:0]           max_gap;
    } summary_t;

    typedef struct {
        logic [FUNC_BITS-1:0]  func;
        logic [STAMP_BITS-1:0] stamp;
        logic [STAMP_BITS-1:0] recv;
        bit                    typed;
        summary_t              answer;
    } probe_t;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              push;
    logic                              full;
    logic [FUNC_BITS-1:0]              i_func;
    logic [STAMP_BITS-1:0]             i_header_stamp;
    logic [STAMP_BITS-1:0]             i_receive_time;
    logic                              empty;
    logic                              pop;
    logic [REASON_BITS-1:0]            o_reason_code;
    logic [OUT_CNT_BITS-1:0]           o_total_count;
    logic [OUT_CNT_BITS-1:0]           o_window_count;
    logic signed [OUT_S_BITS-1:0]      o_last_delay_ns;
    logic signed [OUT_S_BITS-1:0]      o_average_delay_ns;
    logic [OUT_U_BITS-1:0]             o_max_delay_ns;
    logic [OUT_U_BITS-1:0]             o_last_period_ns;
    logic [OUT_U_BITS-1:0]             o_last_jitter_ns;
    logic [OUT_U_BITS-1:0]             o_max_jitter_ns;
    logic [OUT_CNT_BITS-1:0]           o_reordered_count;
    logic [OUT_CNT_BITS-1:0]           o_gap_count;
    logic [OUT_U_BITS-1:0]             o_max_gap_ns;
    logic                              i_cfg_we;
    logic [CFG_ADDR_BITS-1:0]          i_cfg_addr;
    logic [CFG_BITS-1:0]               i_cfg_data;

    stream_timestamp_health_monitor dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_func             (i_func),
        .i_header_stamp     (i_header_stamp),
        .i_receive_time     (i_receive_time),
        .empty              (empty),
        .pop                (pop),
        .o_reason_code      (o_reason_code),
        .o_total_count      (o_total_count),
        .o_window_count     (o_window_count),
        .o_last_delay_ns    (o_last_delay_ns),
        .o_average_delay_ns (o_average_delay_ns),
        .o_max_delay_ns     (o_max_delay_ns),
        .o_last_period_ns   (o_last_period_ns),
        .o_last_jitter_ns   (o_last_jitter_ns),
        .o_max_jitter_ns    (o_max_jitter_ns),
        .o_reordered_count  (o_reordered_count),
        .o_gap_count        (o_gap_count),
        .o_max_gap_ns       (o_max_gap_ns),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data)
    );

    // Mirror of the monitor's statistics and registers.
    logic [STAMP_BITS-1:0]   last_stamp;
    bit                      have_stamp;
    longint                  prior_period;
    bit                      have_period;
    logic [OUT_CNT_BITS-1:0] seen_life, seen_win;
    longint                  delay_sum_life, delay_sum_win;
    longint                  delay_now, delay_top_life, delay_top_win;
    longint                  period_now, jitter_now, jitter_top_life, jitter_top_win;
    logic [OUT_CNT_BITS-1:0] reorder_life, reorder_win, gap_life, gap_win;
    longint                  gap_top;
    logic [CFG_BITS-1:0]     gap_limit, jitter_alarm, jitter_notice;

    summary_t              summaries_due[$];
    probe_t                probes[$];
    logic [STAMP_BITS-1:0] stamp_cursor;
    int                    send_idle_pct;
    int                    take_idle_pct;
    int                    error_count;
    int                    quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [STAMP_BITS-1:0] rand63();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[STAMP_BITS-1:0];
    endfunction

    function automatic longint clamp_time(longint v);
        if (v > TIME_TOP) return TIME_TOP;
        if (v < TIME_BOTTOM) return TIME_BOTTOM;
        return v;
    endfunction

    function automatic logic signed [OUT_S_BITS-1:0] to_s48(longint v);
        longint c;
        c = clamp_time(v);
        return c[OUT_S_BITS-1:0];
    endfunction

    function automatic logic [OUT_U_BITS-1:0] to_u47(longint v);
        if (v < 0) return '0;
        if (v > TIME_TOP) return '1;
        return v[OUT_U_BITS-1:0];
    endfunction

    function automatic logic [OUT_CNT_BITS-1:0] count_up(logic [OUT_CNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic longint add_clamped(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SUM_BOTTOM : SUM_TOP;
        return s;
    endfunction

    function automatic summary_t idle_summary();
        summary_t s;
        s.reason        = REASON_OK;
        s.total_count   = '0;
        s.window_count  = '0;
        s.last_delay    = '0;
        s.average_delay = '0;
        s.max_delay     = '0;
        s.last_period   = '0;
        s.last_jitter   = '0;
        s.max_jitter    = '0;
        s.reordered     = '0;
        s.gaps          = '0;
        s.max_gap       = '0;
        return s;
    endfunction

    task automatic restart_statistics();
        last_stamp      = '0;
        have_stamp      = 1'b0;
        prior_period    = 0;
        have_period     = 1'b0;
        seen_life       = '0;
        seen_win        = '0;
        delay_sum_life  = 0;
        delay_sum_win   = 0;
        delay_now       = 0;
        delay_top_life  = 0;
        delay_top_win   = 0;
        period_now      = 0;
        jitter_now      = 0;
        jitter_top_life = 0;
        jitter_top_win  = 0;
        reorder_life    = '0;
        reorder_win     = '0;
        gap_life        = '0;
        gap_win         = '0;
        gap_top         = 0;
        gap_limit       = GAP_RESET_NS;
        jitter_alarm    = JITTER_HIGH_RESET;
        jitter_notice   = JITTER_WARN_RESET;
    endtask

    task automatic take_sample(input logic [STAMP_BITS-1:0] stamp, input logic [STAMP_BITS-1:0] recv);
        longint delay, period, p, j;
        delay = clamp_time(longint'({1'b0, recv}) - longint'({1'b0, stamp}));
        delay_now      = delay;
        delay_sum_life = add_clamped(delay_sum_life, delay);
        delay_sum_win  = add_clamped(delay_sum_win, delay);
        delay_top_life = (delay > delay_top_life) ? delay : delay_top_life;
        delay_top_win  = (delay > delay_top_win) ? delay : delay_top_win;
        if (have_stamp) begin
            period = longint'({1'b0, stamp}) - longint'({1'b0, last_stamp});
            if (period < 0) begin
                // A stamp going backwards leaves the period and the jitter chain alone.
                reorder_life = count_up(reorder_life);
                reorder_win  = count_up(reorder_win);
            end else if (period > longint'({24'd0, gap_limit})) begin
                p = clamp_time(period);
                gap_life    = count_up(gap_life);
                gap_win     = count_up(gap_win);
                gap_top     = (p > gap_top) ? p : gap_top;
                period_now  = p;
                have_period = 1'b0;
            end else begin
                p = clamp_time(period);
                period_now = p;
                if (have_period) begin
                    j = p - prior_period;
                    if (j < 0) j = -j;
                    jitter_now      = j;
                    jitter_top_life = (j > jitter_top_life) ? j : jitter_top_life;
                    jitter_top_win  = (j > jitter_top_win) ? j : jitter_top_win;
                end
                prior_period = p;
                have_period  = 1'b1;
            end
        end
        last_stamp = stamp;
        have_stamp = 1'b1;
        seen_life  = count_up(seen_life);
        seen_win   = count_up(seen_win);
    endtask

    task automatic answer_query(input bit windowed);
        summary_t                s;
        logic [OUT_CNT_BITS-1:0] cnt, reo, gp;
        longint                  sum, dtop, jtop, avg, divisor;
        cnt  = windowed ? seen_win : seen_life;
        sum  = windowed ? delay_sum_win : delay_sum_life;
        dtop = windowed ? delay_top_win : delay_top_life;
        jtop = windowed ? jitter_top_win : jitter_top_life;
        reo  = windowed ? reorder_win : reorder_life;
        gp   = windowed ? gap_win : gap_life;
        if (reo != 0) begin
            s.reason = REASON_REORDER;
        end else if (gp != 0) begin
            s.reason = REASON_GAP;
        end else if (jtop > longint'({24'd0, jitter_alarm})) begin
            s.reason = REASON_JITTER_HIGH;
        end else if (jtop > longint'({24'd0, jitter_notice})) begin
            s.reason = REASON_JITTER_WARN;
        end else begin
            s.reason = REASON_OK;
        end
        // Signed division truncates toward zero, as the average requires.
        if (cnt == 0) begin
            avg = 0;
        end else begin
            divisor = longint'({32'd0, cnt});
            avg = sum / divisor;
        end
        s.total_count   = seen_life;
        s.window_count  = cnt;
        s.last_delay    = to_s48(delay_now);
        s.average_delay = to_s48(avg);
        s.max_delay     = to_u47(dtop);
        s.last_period   = to_u47(period_now);
        s.last_jitter   = to_u47(jitter_now);
        s.max_jitter    = to_u47(jtop);
        s.reordered     = reo;
        s.gaps          = gp;
        s.max_gap       = to_u47(gap_top);
        summaries_due.push_back(s);
        if (windowed) begin
            seen_win       = '0;
            delay_sum_win  = 0;
            delay_top_win  = 0;
            jitter_top_win = 0;
            reorder_win    = '0;
            gap_win        = '0;
        end
    endtask

    task automatic track_item(input logic [FUNC_BITS-1:0] func,
                              input logic [STAMP_BITS-1:0] stamp,
                              input logic [STAMP_BITS-1:0] recv);
        case (func)
            FUNC_OBSERVE:  take_sample(stamp, recv);
            FUNC_WINDOW:   answer_query(1'b1);
            FUNC_LIFETIME: answer_query(1'b0);
            default: ;
        endcase
    endtask

    task automatic log_failure(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) log_failure($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Sender: optional idle cycles, then hold the transaction until it is taken.
    task automatic offer(input logic [FUNC_BITS-1:0] func,
                         input logic [STAMP_BITS-1:0] stamp,
                         input logic [STAMP_BITS-1:0] recv);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= func;
        i_header_stamp <= stamp;
        i_receive_time <= recv;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_GAP_THRESHOLD: gap_limit = (value < GAP_MIN_NS) ? GAP_MIN_NS : value;
            CFG_JITTER_HIGH:   jitter_alarm = value;
            CFG_JITTER_WARN:   jitter_notice = value;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (summaries_due.size() != 0) @(posedge i_clk);
        // Observes may still sit in the block's queue; ignored transactions never enter it.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly a steady stream around half the gap threshold, with reorders, periods
    // at and just past the threshold, and some wholly random stamps.
    task automatic make_observation(output logic [STAMP_BITS-1:0] stamp,
                                    output logic [STAMP_BITS-1:0] recv);
        logic [STAMP_BITS-1:0] base, off, stride;
        int                    kind;
        base = {23'd0, gap_limit} >> 1;
        case ($urandom_range(3))
            0:       off = $urandom_range(1000);
            1:       off = ({23'd0, jitter_notice} >> 1) + $urandom_range(1000);
            2:       off = ({23'd0, jitter_alarm} >> 1) + $urandom_range(1000);
            default: off = $urandom_range(1 << 20);
        endcase
        if ($urandom_range(1) == 0 || off > base) stride = base + off;
        else stride = base - off;
        kind = $urandom_range(99);
        if (kind < 5) begin
            stamp = rand63();
        end else if (kind < 13) begin
            stamp = stamp_cursor - 1 - $urandom_range(1000000);
        end else if (kind < 21) begin
            stamp = stamp_cursor + gap_limit + $urandom_range(2);
        end else begin
            stamp = stamp_cursor + stride;
        end
        stamp_cursor = stamp;
        if ($urandom_range(99) < 15) recv = rand63();
        else recv = stamp + $urandom_range(5000000) - 1000000;
    endtask

    task automatic run_traffic(input int items);
        logic [FUNC_BITS-1:0]  func;
        logic [STAMP_BITS-1:0] stamp, recv;
        int                    pick;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            stamp = rand63();
            recv  = rand63();
            if (pick < 12) begin
                func = FUNC_WINDOW;
            end else if (pick < 17) begin
                func = FUNC_LIFETIME;
            end else if (pick < 20) begin
                func = FUNC_IGNORED;
            end else begin
                func = FUNC_OBSERVE;
                make_observation(stamp, recv);
            end
            offer(func, stamp, recv);
            track_item(func, stamp, recv);
        end
        push <= 1'b0;
    endtask

    task automatic plan_row(input logic [FUNC_BITS-1:0] func,
                            input logic [STAMP_BITS-1:0] stamp,
                            input logic [STAMP_BITS-1:0] recv);
        probe_t r;
        r.func   = func;
        r.stamp  = stamp;
        r.recv   = recv;
        r.typed  = 1'b0;
        r.answer = idle_summary();
        probes.push_back(r);
    endtask

    task automatic plan_known(input logic [FUNC_BITS-1:0] func,
                              input logic [STAMP_BITS-1:0] stamp,
                              input logic [STAMP_BITS-1:0] recv, input summary_t answer);
        probe_t r;
        r.func   = func;
        r.stamp  = stamp;
        r.recv   = recv;
        r.typed  = 1'b1;
        r.answer = answer;
        probes.push_back(r);
    endtask

    task automatic build_directed();
        summary_t s;
        plan_known(FUNC_WINDOW, '0, '0, idle_summary());
        plan_known(FUNC_LIFETIME, STAMP_TOP, STAMP_TOP, idle_summary());
        // Largest positive delay saturates.
        plan_row(FUNC_OBSERVE, '0, STAMP_TOP);
        s = idle_summary();
        s.total_count   = 1;
        s.window_count  = 1;
        s.last_delay    = S48_MAX;
        s.average_delay = S48_MAX;
        s.max_delay     = U47_MAX;
        plan_known(FUNC_WINDOW, '0, '0, s);
        // Largest negative delay together with the widest possible gap.
        plan_row(FUNC_OBSERVE, STAMP_TOP, '0);
        s = idle_summary();
        s.reason        = REASON_GAP;
        s.total_count   = 2;
        s.window_count  = 1;
        s.last_delay    = S48_MIN;
        s.average_delay = S48_MIN;
        s.last_period   = U47_MAX;
        s.gaps          = 1;
        s.max_gap       = U47_MAX;
        plan_known(FUNC_WINDOW, '0, '0, s);
        plan_row(FUNC_OBSERVE, 63'd5, 63'd5);
        plan_row(FUNC_WINDOW, '0, '0);
        // Jitter chain after the gap: high, then warning, then quiet.
        plan_row(FUNC_OBSERVE, 63'd1_000_005, 63'd1_300_000);
        plan_row(FUNC_OBSERVE, 63'd2_000_005, 63'd1_999_000);
        plan_row(FUNC_OBSERVE, 63'd15_000_005, 63'd15_000_105);
        plan_row(FUNC_WINDOW, '0, '0);
        plan_row(FUNC_OBSERVE, 63'd33_000_005, 63'd33_400_005);
        plan_row(FUNC_WINDOW, '0, '0);
        plan_row(FUNC_OBSERVE, 63'd51_001_005, 63'd51_001_005);
        plan_row(FUNC_WINDOW, '0, '0);
        // A period equal to the threshold is not a gap; one more is.
        plan_row(FUNC_OBSERVE, 63'd151_001_005, 63'd151_101_005);
        plan_row(FUNC_OBSERVE, 63'd251_001_006, 63'd251_001_106);
        plan_row(FUNC_IGNORED, 63'd77, 63'd99);
        plan_row(FUNC_LIFETIME, '0, '0);
        plan_row(FUNC_OBSERVE, 63'd251_001_006, 63'd251_001_006);
        plan_row(FUNC_WINDOW, STAMP_TOP, STAMP_TOP);
    endtask

    initial begin
        logic [STAMP_BITS-1:0] wide;
        push           <= 1'b0;
        pop            <= 1'b0;
        i_func         <= FUNC_OBSERVE;
        i_header_stamp <= '0;
        i_receive_time <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= CFG_GAP_THRESHOLD;
        i_cfg_data     <= '0;
        i_rst_n        <= 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        stamp_cursor  = '0;
        send_idle_pct = 24;
        take_idle_pct = 50;
        restart_statistics();
        build_directed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[k]) begin
            offer(probes[k].func, probes[k].stamp, probes[k].recv);
            track_item(probes[k].func, probes[k].stamp, probes[k].recv);
            if (probes[k].typed) summaries_due[summaries_due.size() - 1] = probes[k].answer;
        end
        push <= 1'b0;
        stamp_cursor = 63'd251_001_006;

        // Lowest settings: the threshold write clamps and any jitter is high.
        settle();
        wide = rand63();
        write_register(CFG_GAP_THRESHOLD, '0);
        write_register(CFG_JITTER_HIGH, '0);
        write_register(CFG_JITTER_WARN, '0);
        write_register(CFG_NONE, wide[CFG_BITS-1:0]);
        i_cfg_we <= 1'b0;
        run_traffic(PHASE_ITEMS);

        settle();
        send_idle_pct = 50;
        take_idle_pct = 24;
        wide = rand63();
        write_register(CFG_GAP_THRESHOLD, '1);
        write_register(CFG_JITTER_HIGH, '1);
        write_register(CFG_JITTER_WARN, wide[CFG_BITS-1:0]);
        i_cfg_we <= 1'b0;
        run_traffic(PHASE_ITEMS);

        settle();
        send_idle_pct = 0;
        take_idle_pct = 0;
        write_register(CFG_GAP_THRESHOLD, 40'(1000000 + $urandom_range(300000000)));
        write_register(CFG_JITTER_HIGH, 40'($urandom_range(50000000)));
        write_register(CFG_JITTER_WARN, 40'($urandom_range(20000000)));
        i_cfg_we <= 1'b0;
        run_traffic(PHASE_ITEMS);

        settle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: pop is raised at random, once per cycle.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= take_idle_pct);
    end

    always @(posedge i_clk) begin
        summary_t want;
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || i_cfg_we) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                log_failure("no transaction for too long");
                $display("DONE: errors detected");
                $finish;
            end
            if (pop && !empty) begin
                if (summaries_due.size() == 0) begin
                    log_failure("summary popped with none outstanding");
                end else begin
                    want = summaries_due.pop_front();
                    check_field("reason_code", o_reason_code, want.reason);
                    check_field("total_count", o_total_count, want.total_count);
                    check_field("window_count", o_window_count, want.window_count);
                    check_field("last_delay_ns", o_last_delay_ns, want.last_delay);
                    check_field("average_delay_ns", o_average_delay_ns, want.average_delay);
                    check_field("max_delay_ns", o_max_delay_ns, want.max_delay);
                    check_field("last_period_ns", o_last_period_ns, want.last_period);
                    check_field("last_jitter_ns", o_last_jitter_ns, want.last_jitter);
                    check_field("max_jitter_ns", o_max_jitter_ns, want.max_jitter);
                    check_field("reordered_count", o_reordered_count, want.reordered);
                    check_field("gap_count", o_gap_count, want.gaps);
                    check_field("max_gap_ns", o_max_gap_ns, want.max_gap);
                end
            end
        end
    end

endmodule
